[sv/lifegen_pkg.sv]
`timescale 1ns / 1ps

package lifegen_pkg;

  localparam int WORD_W = 64;
  localparam int ROW_W  = 16;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ROW_W-1:0]  row_idx_t;

  // three neighboring words of one row: [0] left, [1] center, [2] right
  typedef logic [2:0][WORD_W-1:0] trio_t;

  // 3x3 word neighborhood around the word being evolved
  typedef struct packed {
    trio_t up;
    trio_t mid;
    trio_t dn;
  } window_t;

endpackage

[sv/life_generation_bitpacked.sv]
`timescale 1ns / 1ps

// One generation of Conway Life (B3/S23) over a bit-packed grid that arrives word by word in
// raster order, ROW_WORDS words of 64 cells per row and row_count rows (0 acts as 1). Cells
// outside the grid are dead. The two previous rows live in one ROW_WORDS-deep, 128-bit RAM
// whose entry w holds {older row word, newer row word} for column w; each incoming word does
// a read-modify-write of its own entry, so the row buffers roll without any copy. A 3x3 word
// window of registers feeds a bit-sliced adder tree that evolves 64 cells at once. Result
// (r,w) leaves once word (r+1,w+1) has arrived; the last word of a row also releases the last
// word of the row above, and the last word of the grid flushes the whole last row. An input
// is taken only in idle and passes a load step, then emits its results of the row above; the
// final-row flush does a RAM read, a window load and an evolve for each word of the last row
// in turn, all set by the one RAM port pair and the single evolve unit. Results sit in an
// output register, and a stalled output holds the block in place.
// Register: row_count at byte address 0, reset value 64.
module life_generation_bitpacked #(
  parameter int ROW_WORDS = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  lifegen_pkg::word_t        in_cell_word,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output lifegen_pkg::word_t        out_next_word,
  output lifegen_pkg::row_idx_t     out_row_index,
  output logic [1:0]                out_word_index,
  output logic                      out_last_of_run,
  output logic                      out_grid_done,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import lifegen_pkg::*;

  localparam int WW = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
  localparam logic [WW-1:0] LAST_W = WW'(ROW_WORDS - 1);

  // register index, taken from paddr[2]
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic [ROW_W-1:0] ROW_COUNT_RST = 16'd64;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_LOAD   = 7'b0000010,
    ST_EMIT_A = 7'b0000100,
    ST_EMIT_B = 7'b0001000,
    ST_FL_RD  = 7'b0010000,
    ST_FL_LD  = 7'b0100000,
    ST_EMIT_F = 7'b1000000
  } state_t;

  // shift a new column into the window; a row start clears the older columns
  function automatic window_t shift_in(window_t w, word_t u, word_t m, word_t d,
                                       logic first);
    window_t s;
    s.up  = first ? {u, {WORD_W{1'b0}}, {WORD_W{1'b0}}} : {u, w.up[2], w.up[1]};
    s.mid = first ? {m, {WORD_W{1'b0}}, {WORD_W{1'b0}}} : {m, w.mid[2], w.mid[1]};
    s.dn  = first ? {d, {WORD_W{1'b0}}, {WORD_W{1'b0}}} : {d, w.dn[2], w.dn[1]};
    return s;
  endfunction

  // shift in the dead column right of the row
  function automatic window_t shift_zero(window_t w);
    window_t s;
    s.up  = {{WORD_W{1'b0}}, w.up[2], w.up[1]};
    s.mid = {{WORD_W{1'b0}}, w.mid[2], w.mid[1]};
    s.dn  = {{WORD_W{1'b0}}, w.dn[2], w.dn[1]};
    return s;
  endfunction

  state_t state_r, state_nxt;

  row_idx_t row_count_r;
  row_idx_t rows_m1;

  // position of the next input word
  row_idx_t row_cnt_r;
  logic [WW-1:0] word_cnt_r;

  // transaction being worked on
  word_t    in_word_r;
  row_idx_t cur_row_r;
  logic [WW-1:0] cur_col_r;
  logic     eor_r;
  logic     final_r;

  window_t  win_r, win_nxt;

  row_idx_t emit_row_r, emit_row_nxt;
  logic [WW-1:0] emit_col_r, emit_col_nxt;
  logic     emit_last_r, emit_last_nxt;
  logic     emit_done_r, emit_done_nxt;
  logic [WW-1:0] fl_idx_r, fl_idx_nxt;

  logic     in_fire;
  logic     emitting;
  logic     slot_free;
  logic     emit_fire;
  logic     do_a, do_b, do_f;
  logic     up_ok, mid_ok;

  // row buffer RAM
  logic          ram_we;
  logic          ram_re;
  logic [WW-1:0] ram_raddr;
  logic [2*WORD_W-1:0] ram_wdata;
  logic [2*WORD_W-1:0] ram_rdata;
  word_t         rd_older, rd_newer;

  word_t    eval_word;
  logic [WW+1:0] col_ext;

  // output register
  logic     out_valid_r;
  word_t    out_word_r;
  row_idx_t out_row_r;
  logic [1:0] out_widx_r;
  logic     out_last_r;
  logic     out_done_r;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ROW_COUNT) ? {16'b0, row_count_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_COUNT_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ROW_COUNT) begin
      row_count_r <= pwdata[ROW_W-1:0];
    end
  end

  // a row count of zero behaves as a single row
  assign rows_m1 = (row_count_r == '0) ? '0 : row_count_r - ROW_W'(1);

  // ---------------------------------------------------------------------------
  // handshakes and decode of the current transaction
  // ---------------------------------------------------------------------------
  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign emitting  = (state_r == ST_EMIT_A) || (state_r == ST_EMIT_B) ||
                     (state_r == ST_EMIT_F);
  assign slot_free = !out_valid_r || !out_stall;
  assign emit_fire = emitting && slot_free;

  assign up_ok  = (cur_row_r >= ROW_W'(2));
  assign mid_ok = (cur_row_r != '0);
  // result left of the incoming word, result at the row end, flush of the last row
  assign do_a   = mid_ok && (cur_col_r != '0);
  assign do_b   = mid_ok && eor_r;
  assign do_f   = eor_r && final_r;

  // ---------------------------------------------------------------------------
  // row buffer RAM: read on accept or flush, write back in the load cycle
  // ---------------------------------------------------------------------------
  assign ram_re    = in_fire || (state_r == ST_FL_RD);
  assign ram_raddr = (state_r == ST_IDLE) ? word_cnt_r : fl_idx_r;
  assign ram_we    = (state_r == ST_LOAD);
  // middle row becomes the upper row, the incoming word becomes the middle row
  assign ram_wdata = {rd_newer, in_word_r};
  assign rd_older  = ram_rdata[2*WORD_W-1:WORD_W];
  assign rd_newer  = ram_rdata[WORD_W-1:0];

  lifegen_ram #(
    .WIDTH (2*WORD_W),
    .DEPTH (ROW_WORDS)
  ) u_rowbuf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_col_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lifegen_eval u_eval (
    .win      (win_r),
    .nxt_word (eval_word)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    win_nxt       = win_r;
    emit_row_nxt  = emit_row_r;
    emit_col_nxt  = emit_col_r;
    emit_last_nxt = emit_last_r;
    emit_done_nxt = emit_done_r;
    fl_idx_nxt    = fl_idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        win_nxt = shift_in(win_r, up_ok ? rd_older : '0, mid_ok ? rd_newer : '0,
                           in_word_r, cur_col_r == '0);
        emit_row_nxt  = cur_row_r - ROW_W'(1);
        emit_done_nxt = 1'b0;
        fl_idx_nxt    = '0;
        if (do_a) begin
          state_nxt     = ST_EMIT_A;
          emit_col_nxt  = cur_col_r - WW'(1);
          emit_last_nxt = !(do_b || do_f);
        end else if (do_b) begin
          // single-word row: the word is also the row end
          win_nxt       = shift_zero(win_nxt);
          state_nxt     = ST_EMIT_B;
          emit_col_nxt  = cur_col_r;
          emit_last_nxt = !do_f;
        end else if (do_f) begin
          state_nxt = ST_FL_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_A: begin
        if (emit_fire) begin
          if (do_b) begin
            win_nxt       = shift_zero(win_r);
            state_nxt     = ST_EMIT_B;
            emit_col_nxt  = cur_col_r;
            emit_last_nxt = !do_f;
          end else if (do_f) begin
            state_nxt = ST_FL_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT_B: begin
        if (emit_fire) begin
          state_nxt = do_f ? ST_FL_RD : ST_IDLE;
        end
      end
      ST_FL_RD: begin
        state_nxt = ST_FL_LD;
      end
      ST_FL_LD: begin
        // flush window: middle row above, last row in the center, dead row below
        win_nxt = shift_in(win_r, mid_ok ? rd_older : '0, rd_newer, '0, fl_idx_r == '0);
        emit_row_nxt = cur_row_r;
        if (fl_idx_r == '0 && fl_idx_r != LAST_W) begin
          fl_idx_nxt = fl_idx_r + WW'(1);
          state_nxt  = ST_FL_RD;
        end else if (fl_idx_r == '0) begin
          win_nxt       = shift_zero(win_nxt);
          state_nxt     = ST_EMIT_F;
          emit_col_nxt  = '0;
          emit_last_nxt = 1'b1;
          emit_done_nxt = 1'b1;
        end else begin
          state_nxt     = ST_EMIT_F;
          emit_col_nxt  = fl_idx_r - WW'(1);
          emit_last_nxt = 1'b0;
          emit_done_nxt = 1'b0;
        end
      end
      ST_EMIT_F: begin
        if (emit_fire) begin
          if (emit_col_r == LAST_W) begin
            state_nxt = ST_IDLE;
          end else if (fl_idx_r != LAST_W) begin
            fl_idx_nxt = fl_idx_r + WW'(1);
            state_nxt  = ST_FL_RD;
          end else begin
            // last word of the grid, right neighbor is dead
            win_nxt       = shift_zero(win_r);
            emit_col_nxt  = LAST_W;
            emit_last_nxt = 1'b1;
            emit_done_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_cnt_r   <= '0;
      word_cnt_r  <= '0;
      eor_r       <= 1'b0;
      final_r     <= 1'b0;
      emit_last_r <= 1'b0;
      emit_done_r <= 1'b0;
      fl_idx_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      emit_last_r <= emit_last_nxt;
      emit_done_r <= emit_done_nxt;
      fl_idx_r    <= fl_idx_nxt;
      if (in_fire) begin
        eor_r   <= (word_cnt_r == LAST_W);
        final_r <= (row_cnt_r >= rows_m1);
        if (word_cnt_r == LAST_W) begin
          word_cnt_r <= '0;
          // the last row (or a row past a shrunken row count) restarts the grid
          row_cnt_r  <= (row_cnt_r >= rows_m1) ? '0 : row_cnt_r + ROW_W'(1);
        end else begin
          word_cnt_r <= word_cnt_r + WW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_word_r <= in_cell_word;
      cur_row_r <= row_cnt_r;
      cur_col_r <= word_cnt_r;
    end
    win_r        <= win_nxt;
    emit_row_r   <= emit_row_nxt;
    emit_col_r   <= emit_col_nxt;
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  assign col_ext = {2'b00, emit_col_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_word_r <= eval_word;
      out_row_r  <= emit_row_r;
      out_widx_r <= col_ext[1:0];
      out_last_r <= emit_last_r;
      out_done_r <= emit_done_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_word   = out_word_r;
  assign out_row_index   = out_row_r;
  assign out_word_index  = out_widx_r;
  assign out_last_of_run = out_last_r;
  assign out_grid_done   = out_done_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_LOAD)
    else $error("accepted transaction not followed by a load cycle");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_grid_done |-> out_last_of_run)
    else $error("grid end without end of run");

  a_emit_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    emitting |-> emit_col_r <= LAST_W)
    else $error("emitted column beyond the row");

  a_flush_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT_F |-> fl_idx_r >= emit_col_r)
    else $error("flush emits a column not yet read");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> out_valid)
    else $error("emitted result lost");

endmodule

[sv/lifegen_ram.sv]
`timescale 1ns / 1ps

module lifegen_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 4,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/lifegen_eval.sv]
`timescale 1ns / 1ps

module lifegen_eval (
  input  lifegen_pkg::window_t win,
  output lifegen_pkg::word_t   nxt_word
);
  import lifegen_pkg::*;

  typedef struct packed {
    word_t s;
    word_t c;
  } pair_t;

  // horizontal three-cell sum of one row, per lane
  function automatic pair_t row_sum(trio_t t);
    word_t west;
    word_t east;
    pair_t p;
    west = (t[1] << 1) | {{(WORD_W-1){1'b0}}, t[0][WORD_W-1]};
    east = (t[1] >> 1) | {t[2][0], {(WORD_W-1){1'b0}}};
    p.s  = west ^ t[1] ^ east;
    p.c  = (west & t[1]) | (west & east) | (t[1] & east);
    return p;
  endfunction

  pair_t ra, rb, rc;
  word_t bit0, cn, t0, t1, k1, t2, k2, k3, eq3, eq4;

  always_comb begin
    ra   = row_sum(win.up);
    rb   = row_sum(win.mid);
    rc   = row_sum(win.dn);
    bit0 = ra.s ^ rb.s ^ rc.s;
    cn   = (ra.s & rb.s) | (ra.s & rc.s) | (rb.s & rc.s);
    t0   = ra.c ^ rb.c ^ rc.c;
    t1   = (ra.c & rb.c) | (ra.c & rc.c) | (rb.c & rc.c);
    k1   = t0 ^ cn;
    t2   = t0 & cn;
    k2   = t1 ^ t2;
    k3   = t1 & t2;
    // 3x3 sum includes the cell itself: 3 births or survives, 4 survives
    eq4  = ~k3 & k2 & ~k1 & ~bit0;
    eq3  = ~k3 & ~k2 & k1 & bit0;
  end

  assign nxt_word = eq3 | (win.mid[1] & eq4);

endmodule
